// ===== sv/obb_pkg.sv =====
// Shared constants and helpers for the oriented-box overlap pipeline.
`timescale 1ns / 1ps

package obb_pkg;

    // Every input field is a packed triple in a 48-bit word
    localparam int FIELD_W        = 48;
    localparam int NUM_FIELDS     = 10;
    localparam int NUM_COMPS      = 3;
    // A's three axes, then B's three
    localparam int NUM_AXES       = 6;
    // Distinct entries of the symmetric 6x6 axis dot-product matrix
    localparam int NUM_PAIRS      = NUM_AXES * (NUM_AXES + 1) / 2;
    localparam int NUM_STAGES     = 6;
    localparam int DEF_COMP_WIDTH = 16;

    // Slot of axis pair (i, j) in the packed upper triangle, either order
    function automatic int pair_index(input int i, input int j);
        int lo;
        int hi;
        lo = (i < j) ? i : j;
        hi = (i < j) ? j : i;
        return lo * NUM_AXES - (lo * (lo - 1)) / 2 + (hi - lo);
    endfunction

endpackage

// ===== sv/obb_pair_overlap_test.sv =====
// Face-axis separating-axis overlap test for two oriented boxes, six stages deep.
`timescale 1ns / 1ps

// One box pair per beat, one hit flag per beat, in order. The pipeline is six
// register stages (field unpack, component products, dot sums, half-size
// products, radius sums, compare), each holding one pair, and a new pair can be
// taken every cycle while the output side does not stall. Only the six face
// axes are tried; touching boxes report a hit.
// Each stage holds while the stage after it is full and stalled, so bubbles
// are squeezed out and s_ready drops only when every stage is occupied.
// COMPONENT_WIDTH sets the width of each packed component; components that
// would lie above bit 47 of a field read as zero.
module obb_pair_overlap_test
    import obb_pkg::*;
#(
    parameter int COMPONENT_WIDTH = DEF_COMP_WIDTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [FIELD_W-1:0] s_center_a,
    input  logic [FIELD_W-1:0] s_axis_x_a,
    input  logic [FIELD_W-1:0] s_axis_y_a,
    input  logic [FIELD_W-1:0] s_axis_z_a,
    input  logic [FIELD_W-1:0] s_half_size_a,
    input  logic [FIELD_W-1:0] s_center_b,
    input  logic [FIELD_W-1:0] s_axis_x_b,
    input  logic [FIELD_W-1:0] s_axis_y_b,
    input  logic [FIELD_W-1:0] s_axis_z_b,
    input  logic [FIELD_W-1:0] s_half_size_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit
);

    localparam int W     = COMPONENT_WIDTH;
    localparam int EXT_W = NUM_COMPS * W;
    localparam int DW    = W + 1;        // center difference
    localparam int DPW   = 2 * W + 1;    // difference times axis component
    localparam int GPW   = 2 * W;        // axis component times axis component
    localparam int DSW   = 2 * W + 3;    // projected distance dot
    localparam int GSW   = 2 * W + 2;    // axis-axis dot
    localparam int SPLIT = W + 1;        // low slice of |axis-axis dot|
    localparam int GHW   = GSW - SPLIT;  // high slice
    localparam int PPW   = 2 * W + 1;    // half-size times one slice
    localparam int RSW   = 2 * W + 4;    // sum of six slice products
    localparam int RW    = 3 * W + 6;    // full radius and scaled distance
    localparam int FRAC  = W - 2;        // axis fraction bits

    // ---------------- handshake: per-stage valid and ready ----------------
    logic valid_reg   [NUM_STAGES];
    logic stage_ready [NUM_STAGES];

    always_comb begin
        stage_ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign s_ready = stage_ready[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else begin
            if (stage_ready[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: unpack fields ----------------
    logic [FIELD_W-1:0]  field_in [NUM_FIELDS];
    logic [EXT_W-1:0]    field_ext [NUM_FIELDS];
    logic signed [W-1:0] comp [NUM_FIELDS][NUM_COMPS];

    assign field_in[0] = s_center_a;
    assign field_in[1] = s_axis_x_a;
    assign field_in[2] = s_axis_y_a;
    assign field_in[3] = s_axis_z_a;
    assign field_in[4] = s_half_size_a;
    assign field_in[5] = s_center_b;
    assign field_in[6] = s_axis_x_b;
    assign field_in[7] = s_axis_y_b;
    assign field_in[8] = s_axis_z_b;
    assign field_in[9] = s_half_size_b;

    for (genvar f = 0; f < NUM_FIELDS; f++) begin : g_unpack
        // bits above the 48-bit field read as zero
        if (EXT_W > FIELD_W) begin : g_pad
            assign field_ext[f] = {{(EXT_W - FIELD_W){1'b0}}, field_in[f]};
        end else begin : g_cut
            assign field_ext[f] = field_in[f][EXT_W-1:0];
        end
        for (genvar c = 0; c < NUM_COMPS; c++) begin : g_comp
            assign comp[f][c] = field_ext[f][c*W +: W];
        end
    end

    logic signed [DW-1:0] d_next [NUM_COMPS];
    logic signed [W-1:0]  axis_next [NUM_AXES][NUM_COMPS];
    logic [W-1:0]         hsm_next [NUM_AXES];

    always_comb begin
        for (int c = 0; c < NUM_COMPS; c++) begin
            d_next[c] = DW'(comp[5][c]) - DW'(comp[0][c]);
        end
        for (int b = 0; b < 2; b++) begin
            for (int k = 0; k < NUM_COMPS; k++) begin
                for (int c = 0; c < NUM_COMPS; c++) begin
                    axis_next[3*b+k][c] = comp[5*b+1+k][c];
                end
                // negative half-size counts by its magnitude
                hsm_next[3*b+k] = comp[5*b+4][k][W-1] ? W'(-comp[5*b+4][k])
                                                      : W'(comp[5*b+4][k]);
            end
        end
    end

    logic signed [DW-1:0] s1_d_reg [NUM_COMPS];
    logic signed [W-1:0]  s1_axis_reg [NUM_AXES][NUM_COMPS];
    logic [W-1:0]         s1_hsm_reg [NUM_AXES];

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            s1_d_reg    <= d_next;
            s1_axis_reg <= axis_next;
            s1_hsm_reg  <= hsm_next;
        end
    end

    // ---------------- stage 2: component products ----------------
    logic signed [DPW-1:0] dp_next [NUM_AXES][NUM_COMPS];
    logic signed [GPW-1:0] gp_next [NUM_PAIRS][NUM_COMPS];

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            for (int c = 0; c < NUM_COMPS; c++) begin
                dp_next[i][c] = DPW'(s1_d_reg[c]) * DPW'(s1_axis_reg[i][c]);
            end
        end
    end

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_gram_row
        for (genvar j = i; j < NUM_AXES; j++) begin : g_gram_col
            localparam int PI = pair_index(i, j);
            for (genvar c = 0; c < NUM_COMPS; c++) begin : g_gram_comp
                assign gp_next[PI][c] = GPW'(s1_axis_reg[i][c]) * GPW'(s1_axis_reg[j][c]);
            end
        end
    end

    logic signed [DPW-1:0] s2_dp_reg [NUM_AXES][NUM_COMPS];
    logic signed [GPW-1:0] s2_gp_reg [NUM_PAIRS][NUM_COMPS];
    logic [W-1:0]          s2_hsm_reg [NUM_AXES];

    always_ff @(posedge aclk) begin
        if (stage_ready[1]) begin
            s2_dp_reg  <= dp_next;
            s2_gp_reg  <= gp_next;
            s2_hsm_reg <= s1_hsm_reg;
        end
    end

    // ---------------- stage 3: dot sums and magnitudes ----------------
    logic signed [DSW-1:0] dsum [NUM_AXES];
    logic signed [GSW-1:0] gsum [NUM_PAIRS];
    logic [DSW-1:0]        dm_next [NUM_AXES];
    logic [GSW-1:0]        gm_next [NUM_PAIRS];

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            dsum[i] = DSW'(s2_dp_reg[i][0]) + DSW'(s2_dp_reg[i][1])
                    + DSW'(s2_dp_reg[i][2]);
            dm_next[i] = dsum[i][DSW-1] ? DSW'(-dsum[i]) : DSW'(dsum[i]);
        end
        for (int p = 0; p < NUM_PAIRS; p++) begin
            gsum[p] = GSW'(s2_gp_reg[p][0]) + GSW'(s2_gp_reg[p][1])
                    + GSW'(s2_gp_reg[p][2]);
            gm_next[p] = gsum[p][GSW-1] ? GSW'(-gsum[p]) : GSW'(gsum[p]);
        end
    end

    logic [DSW-1:0] s3_dm_reg [NUM_AXES];
    logic [GSW-1:0] s3_gm_reg [NUM_PAIRS];
    logic [W-1:0]   s3_hsm_reg [NUM_AXES];

    always_ff @(posedge aclk) begin
        if (stage_ready[2]) begin
            s3_dm_reg  <= dm_next;
            s3_gm_reg  <= gm_next;
            s3_hsm_reg <= s2_hsm_reg;
        end
    end

    // ---------------- stage 4: half-size times split axis dot ----------------
    logic [GSW-1:0] gsel [NUM_AXES][NUM_AXES];
    logic [PPW-1:0] pl_next [NUM_AXES][NUM_AXES];
    logic [PPW-1:0] ph_next [NUM_AXES][NUM_AXES];

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_sel_row
        for (genvar m = 0; m < NUM_AXES; m++) begin : g_sel_col
            localparam int PI = pair_index(i, m);
            assign gsel[i][m] = s3_gm_reg[PI];
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            for (int m = 0; m < NUM_AXES; m++) begin
                pl_next[i][m] = PPW'(s3_hsm_reg[m]) * PPW'(gsel[i][m][SPLIT-1:0]);
                ph_next[i][m] = PPW'(s3_hsm_reg[m]) * PPW'(gsel[i][m][GSW-1 -: GHW]);
            end
        end
    end

    logic [PPW-1:0] s4_pl_reg [NUM_AXES][NUM_AXES];
    logic [PPW-1:0] s4_ph_reg [NUM_AXES][NUM_AXES];
    logic [DSW-1:0] s4_dm_reg [NUM_AXES];

    always_ff @(posedge aclk) begin
        if (stage_ready[3]) begin
            s4_pl_reg <= pl_next;
            s4_ph_reg <= ph_next;
            s4_dm_reg <= s3_dm_reg;
        end
    end

    // ---------------- stage 5: radius slice sums ----------------
    logic [RSW-1:0] rl_next [NUM_AXES];
    logic [RSW-1:0] rh_next [NUM_AXES];

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            rl_next[i] = '0;
            rh_next[i] = '0;
            for (int m = 0; m < NUM_AXES; m++) begin
                rl_next[i] = rl_next[i] + RSW'(s4_pl_reg[i][m]);
                rh_next[i] = rh_next[i] + RSW'(s4_ph_reg[i][m]);
            end
        end
    end

    logic [RSW-1:0] s5_rl_reg [NUM_AXES];
    logic [RSW-1:0] s5_rh_reg [NUM_AXES];
    logic [DSW-1:0] s5_dm_reg [NUM_AXES];

    always_ff @(posedge aclk) begin
        if (stage_ready[4]) begin
            s5_rl_reg <= rl_next;
            s5_rh_reg <= rh_next;
            s5_dm_reg <= s4_dm_reg;
        end
    end

    // ---------------- stage 6: distance against radius ----------------
    logic [RW-1:0]       radius [NUM_AXES];
    logic [RW-1:0]       reach [NUM_AXES];
    logic [NUM_AXES-1:0] sep;
    logic                hit_next;
    logic                hit_reg;

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            radius[i] = (RW'(s5_rh_reg[i]) << SPLIT) + RW'(s5_rl_reg[i]);
            reach[i]  = RW'(s5_dm_reg[i]) << FRAC;
            sep[i]    = reach[i] > radius[i];
        end
        // touching is still a hit
        hit_next = ~|sep;
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[5]) begin
            hit_reg <= hit_next;
        end
    end

    assign m_hit = hit_reg;

endmodule

// ===== dv/tb_obb_pair_overlap_test.sv =====
// Self-checking testbench for the face-axis oriented-box overlap pipeline.
`timescale 1ns / 1ps

module tb_obb_pair_overlap_test
    import obb_pkg::*;
();

    localparam int     CW           = DEF_COMP_WIDTH;
    localparam int     AXIS_FRAC    = CW - 2;
    localparam longint UNIT         = longint'(1) << AXIS_FRAC;
    localparam longint MAXC         = (longint'(1) << (CW - 1)) - 1;
    localparam longint MINC         = -(longint'(1) << (CW - 1));
    localparam int     PERIOD       = 10;
    localparam int     RANDOM_PAIRS = 690;
    localparam int     LONG_HOLD    = 80;
    localparam int     DRAIN_CYCLES = 4 * NUM_STAGES;
    localparam int     STALL_LIMIT  = 3000;

    typedef logic [FIELD_W-1:0] field_t;

    typedef struct packed {
        field_t half_size_b;
        field_t axis_z_b;
        field_t axis_y_b;
        field_t axis_x_b;
        field_t center_b;
        field_t half_size_a;
        field_t axis_z_a;
        field_t axis_y_a;
        field_t axis_x_a;
        field_t center_a;
    } box_pair_t;

    logic   aclk    = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    field_t s_center_a    = '0;
    field_t s_axis_x_a    = '0;
    field_t s_axis_y_a    = '0;
    field_t s_axis_z_a    = '0;
    field_t s_half_size_a = '0;
    field_t s_center_b    = '0;
    field_t s_axis_x_b    = '0;
    field_t s_axis_y_b    = '0;
    field_t s_axis_z_b    = '0;
    field_t s_half_size_b = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    logic   m_hit;

    box_pair_t pair_backlog[$];
    logic      hit_expected[$];
    box_pair_t on_bus;

    int errors        = 0;
    int pairs_sent    = 0;
    int results_seen  = 0;
    int hits_seen     = 0;
    int quiet_cycles  = 0;
    int send_gap      = 0;
    int send_run_left = 0;
    bit send_sparse   = 1'b0;
    int recv_stall    = 0;
    int recv_run_left = 0;
    bit recv_sparse   = 1'b0;

    obb_pair_overlap_test #(
        .COMPONENT_WIDTH(CW)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_center_a   (s_center_a),
        .s_axis_x_a   (s_axis_x_a),
        .s_axis_y_a   (s_axis_y_a),
        .s_axis_z_a   (s_axis_z_a),
        .s_half_size_a(s_half_size_a),
        .s_center_b   (s_center_b),
        .s_axis_x_b   (s_axis_x_b),
        .s_axis_y_b   (s_axis_y_b),
        .s_axis_z_b   (s_axis_z_b),
        .s_half_size_b(s_half_size_b),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit)
    );

    always #(PERIOD / 2) aclk = ~aclk;

    // Signed component c of a packed triple; bits above the field read as zero
    function automatic longint comp_of(field_t v, int c);
        logic [63:0] u;
        u = 64'(v) >> (c * CW);
        u = u & ((64'd1 << CW) - 64'd1);
        if (u[CW-1]) return longint'(u) - (longint'(1) << CW);
        return longint'(u);
    endfunction

    function automatic logic [127:0] mag(longint x);
        return (x < 0) ? 128'(-x) : 128'(x);
    endfunction

    function automatic field_t pack3(longint x, longint y, longint z);
        field_t m;
        m = field_t'((longint'(1) << CW) - 1);
        return (field_t'(x) & m) | ((field_t'(y) & m) << CW) | ((field_t'(z) & m) << (2 * CW));
    endfunction

    function automatic field_t rand48();
        return field_t'({$urandom(), $urandom()});
    endfunction

    function automatic longint srand(int unsigned span);
        return longint'($urandom_range(0, 2 * span)) - longint'(span);
    endfunction

    // Face-axis test: no hit as soon as one of the six axes separates the boxes.
    // Sums are kept wide enough to be exact at the default component width.
    function automatic logic boxes_overlap(box_pair_t bp);
        field_t       cf[2];
        field_t       hf[2];
        field_t       af[2][3];
        longint       ctr[2][3];
        longint       hs[2][3];
        longint       ax[2][3][3];
        longint       d[3];
        longint       dp;
        logic [127:0] reach;
        logic [127:0] radius;
        cf[0] = bp.center_a;    cf[1] = bp.center_b;
        hf[0] = bp.half_size_a; hf[1] = bp.half_size_b;
        af[0][0] = bp.axis_x_a; af[0][1] = bp.axis_y_a; af[0][2] = bp.axis_z_a;
        af[1][0] = bp.axis_x_b; af[1][1] = bp.axis_y_b; af[1][2] = bp.axis_z_b;
        for (int b = 0; b < 2; b++) begin
            for (int c = 0; c < NUM_COMPS; c++) begin
                ctr[b][c] = comp_of(cf[b], c);
                hs[b][c]  = comp_of(hf[b], c);
                for (int k = 0; k < 3; k++) ax[b][k][c] = comp_of(af[b][k], c);
            end
        end
        for (int c = 0; c < NUM_COMPS; c++) d[c] = ctr[1][c] - ctr[0][c];
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 3; j++) begin
                dp = 0;
                for (int c = 0; c < NUM_COMPS; c++) dp += d[c] * ax[i][j][c];
                // center distance brought to the pos*axis*axis scale of the radius
                reach = mag(dp) << AXIS_FRAC;
                radius = '0;
                for (int b = 0; b < 2; b++) begin
                    for (int k = 0; k < 3; k++) begin
                        dp = 0;
                        for (int c = 0; c < NUM_COMPS; c++) dp += ax[b][k][c] * ax[i][j][c];
                        radius += mag(hs[b][k]) * mag(dp);
                    end
                end
                if (reach > radius) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic queue_pair(input field_t ca, xa, ya, za, ha, cb, xb, yb, zb, hb);
        box_pair_t bp;
        bp.center_a = ca; bp.axis_x_a = xa; bp.axis_y_a = ya; bp.axis_z_a = za;
        bp.half_size_a = ha;
        bp.center_b = cb; bp.axis_x_b = xb; bp.axis_y_b = yb; bp.axis_z_b = zb;
        bp.half_size_b = hb;
        pair_backlog.push_back(bp);
    endtask

    // Orthonormal-ish frame: a rotation about one coordinate axis, random signs
    task automatic rand_axes(output field_t x, output field_t y, output field_t z);
        longint cv;
        longint sv;
        longint a0[3];
        longint a1[3];
        longint a2[3];
        int     r;
        case ($urandom_range(0, 4))
            0: begin cv = UNIT;              sv = 0;                  end
            1: begin cv = UNIT * 7071 / 10000; sv = UNIT * 7071 / 10000; end
            2: begin cv = UNIT * 8660 / 10000; sv = UNIT / 2;           end
            3: begin cv = UNIT * 3 / 5;      sv = UNIT * 4 / 5;       end
            default: begin cv = UNIT * 9659 / 10000; sv = UNIT * 2588 / 10000; end
        endcase
        if ($urandom_range(0, 1)) cv = -cv;
        if ($urandom_range(0, 1)) sv = -sv;
        r = $urandom_range(0, 2);
        a0 = '{0, 0, 0};
        a1 = '{0, 0, 0};
        a2 = '{0, 0, 0};
        a0[(r + 1) % 3] = cv;
        a0[(r + 2) % 3] = sv;
        a1[(r + 1) % 3] = -sv;
        a1[(r + 2) % 3] = cv;
        a2[r] = $urandom_range(0, 1) ? UNIT : -UNIT;
        x = pack3(a0[0], a0[1], a0[2]);
        y = pack3(a1[0], a1[1], a1[2]);
        z = pack3(a2[0], a2[1], a2[2]);
    endtask

    // Plausible box pair; on_edge puts two aligned boxes exactly touching or one LSB apart
    task automatic make_box_pair(input bit on_edge, output box_pair_t bp);
        longint ha[3];
        longint hb[3];
        longint ca[3];
        longint cb[3];
        int     c;
        rand_axes(bp.axis_x_a, bp.axis_y_a, bp.axis_z_a);
        rand_axes(bp.axis_x_b, bp.axis_y_b, bp.axis_z_b);
        for (int k = 0; k < 3; k++) begin
            ha[k] = $urandom_range(0, 1024);
            hb[k] = $urandom_range(0, 1024);
            ca[k] = srand(8000);
            cb[k] = ca[k] + srand(2500);
        end
        if (on_edge) begin
            bp.axis_x_a = pack3(UNIT, 0, 0);
            bp.axis_y_a = pack3(0, UNIT, 0);
            bp.axis_z_a = pack3(0, 0, UNIT);
            bp.axis_x_b = bp.axis_x_a;
            bp.axis_y_b = bp.axis_y_a;
            bp.axis_z_b = bp.axis_z_a;
            for (int k = 0; k < 3; k++) cb[k] = ca[k] + srand(int'(ha[k] + hb[k]));
            c = $urandom_range(0, 2);
            cb[c] = ha[c] + hb[c] + $urandom_range(0, 1);
            cb[c] = $urandom_range(0, 1) ? ca[c] + cb[c] : ca[c] - cb[c];
        end
        bp.center_a    = pack3(ca[0], ca[1], ca[2]);
        bp.center_b    = pack3(cb[0], cb[1], cb[2]);
        bp.half_size_a = pack3(ha[0], ha[1], ha[2]);
        bp.half_size_b = pack3(hb[0], hb[1], hb[2]);
    endtask

    task automatic report_error(input string msg);
        errors++;
        if (errors <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Sender: one pair per beat, random gaps between beats, payload held while stalled
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
            send_run_left = 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                hit_expected.push_back(boxes_overlap(on_bus));
                pairs_sent++;
                if (send_run_left == 0) begin
                    send_sparse = ($urandom_range(0, 2) != 0);
                    send_run_left = $urandom_range(10, 40);
                end
                send_run_left--;
                send_gap = send_sparse ? $urandom_range(0, 7) : 0;
            end
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pair_backlog.size() != 0) begin
                on_bus = pair_backlog.pop_front();
                s_center_a    <= on_bus.center_a;
                s_axis_x_a    <= on_bus.axis_x_a;
                s_axis_y_a    <= on_bus.axis_y_a;
                s_axis_z_a    <= on_bus.axis_z_a;
                s_half_size_a <= on_bus.half_size_a;
                s_center_b    <= on_bus.center_b;
                s_axis_x_b    <= on_bus.axis_x_b;
                s_axis_y_b    <= on_bus.axis_y_b;
                s_axis_z_b    <= on_bus.axis_z_b;
                s_half_size_b <= on_bus.half_size_b;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each hit flag in order, random stalls plus two long hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall = 0;
            recv_run_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (hit_expected.size() == 0) begin
                    report_error($sformatf("unexpected result beat, hit=%b", m_hit));
                end else if (m_hit !== hit_expected[0]) begin
                    report_error($sformatf("result %0d: hit expected %b, got %b",
                                           results_seen, hit_expected[0], m_hit));
                end
                if (hit_expected.size() != 0) void'(hit_expected.pop_front());
                results_seen++;
                if (m_hit === 1'b1) hits_seen++;
                if (recv_run_left == 0) begin
                    recv_sparse = ($urandom_range(0, 2) != 0);
                    recv_run_left = $urandom_range(10, 40);
                end
                recv_run_left--;
                recv_stall = recv_sparse ? $urandom_range(0, 7) : 0;
                // long back-pressure so the pipeline fills and drops s_ready
                if (results_seen == 150 || results_seen == 450) recv_stall = LONG_HOLD;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without a beat on either side ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no beat for %0d cycles, %0d results outstanding",
                     $realtime, quiet_cycles, hit_expected.size());
            $display("tb_obb_pair_overlap_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        field_t    ix;
        field_t    iy;
        field_t    iz;
        field_t    h64;
        field_t    hneg;
        field_t    cmin;
        field_t    cmax;
        field_t    r45x;
        field_t    r45y;
        box_pair_t bp;
        int        pick;

        ix   = pack3(UNIT, 0, 0);
        iy   = pack3(0, UNIT, 0);
        iz   = pack3(0, 0, UNIT);
        h64  = pack3(64, 64, 64);
        hneg = pack3(-64, -64, -64);
        cmin = pack3(MINC, MINC, MINC);
        cmax = pack3(MAXC, MAXC, MAXC);
        r45x = pack3(UNIT * 7071 / 10000, UNIT * 7071 / 10000, 0);
        r45y = pack3(-UNIT * 7071 / 10000, UNIT * 7071 / 10000, 0);

        // Directed: degenerate words, touching and just-apart faces on every axis
        queue_pair('0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        queue_pair('1, '1, '1, '1, '1, '1, '1, '1, '1, '1);
        queue_pair('0, ix, iy, iz, h64, pack3(128, 0, 0), ix, iy, iz, h64);
        queue_pair('0, ix, iy, iz, h64, pack3(129, 0, 0), ix, iy, iz, h64);
        queue_pair('0, ix, iy, iz, h64, pack3(0, -128, 0), ix, iy, iz, h64);
        queue_pair('0, ix, iy, iz, h64, pack3(0, -129, 0), ix, iy, iz, h64);
        queue_pair('0, ix, iy, iz, h64, pack3(0, 0, 128), ix, iy, iz, h64);
        queue_pair('0, ix, iy, iz, h64, pack3(0, 0, 129), ix, iy, iz, h64);
        // negative half-sizes count by magnitude
        queue_pair('0, ix, iy, iz, hneg, pack3(128, 0, 0), ix, iy, iz, hneg);
        queue_pair('0, ix, iy, iz, hneg, pack3(129, 0, 0), ix, iy, iz, hneg);
        // zero axes never separate; only B's axes can here
        queue_pair('0, '0, '0, '0, h64, pack3(5000, 5000, 5000), '0, '0, '0, h64);
        queue_pair('0, '0, '0, '0, h64, pack3(5000, 5000, 5000), ix, iy, iz, h64);
        // non-unit axes used as given
        queue_pair('0, pack3(MAXC, 0, 0), pack3(0, MAXC, 0), iz, h64,
                   pack3(200, 0, 0), ix, iy, iz, h64);
        // extreme centers and half-sizes
        queue_pair(cmin, ix, iy, iz, '0, cmax, ix, iy, iz, '0);
        queue_pair(cmin, ix, iy, iz, cmax, cmax, ix, iy, iz, cmax);
        queue_pair(cmin, cmin, cmax, pack3(MINC, MAXC, 0), cmin,
                   cmax, cmax, cmin, pack3(0, MINC, MAXC), cmin);
        // rotated B near A's face
        queue_pair('0, ix, iy, iz, h64, pack3(155, 0, 0), r45x, r45y, iz, h64);
        queue_pair('0, ix, iy, iz, h64, pack3(157, 0, 0), r45x, r45y, iz, h64);
        for (int n = 0; n < 3; n++) begin
            queue_pair(rand48(), rand48(), rand48(), rand48(), rand48(),
                       rand48(), rand48(), rand48(), rand48(), rand48());
        end

        // Random: mostly plausible pairs, some raw noise and corrupted pairs
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                for (int f = 0; f < NUM_FIELDS; f++) bp[f * FIELD_W +: FIELD_W] = rand48();
            end else begin
                make_box_pair(pick >= 25 && pick < 40, bp);
                if (pick < 25) begin
                    case ($urandom_range(0, 3))
                        0: bp.axis_y_a = '0;
                        1: bp.half_size_b = rand48();
                        2: bp.axis_z_b = rand48();
                        default: bp.center_a = rand48();
                    endcase
                end
            end
            pair_backlog.push_back(bp);
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pair_backlog.size() != 0 || s_valid || hit_expected.size() != 0) begin
            @(posedge aclk);
            #1;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        #1;

        $display("Sent %0d box pairs (directed edges plus random/noise), received %0d results",
                 pairs_sent, results_seen);
        $display("  %0d overlapping, %0d separated, %0d errors",
                 hits_seen, results_seen - hits_seen, errors);
        if (errors == 0) begin
            $display("tb_obb_pair_overlap_test OK");
        end else begin
            $display("tb_obb_pair_overlap_test NOT OK");
        end
        $finish;
    end

endmodule
